FILE: sv/spq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by every module of the block.
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int VALUE_W     = 32;
    localparam int PRIO_W      = 16;
    localparam int ENTRY_W     = 5;

    // Stream widths, padded to whole bytes.
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 88;

    // Operation codes carried on tuser.
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    // Commands from controller to datapath.
    typedef struct packed {
        logic exec;      // apply the incoming operation to the slot chain
        logic load_out;  // capture the result into the output register
    } t_dp_cmd;

endpackage

FILE: sv/spq_ctrl.sv
`timescale 1ns / 1ps
// Controller for the sorted priority queue: handshakes and sequencing.
// Depends on spq_pkg.
module spq_ctrl
    import spq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    output t_dp_cmd o_cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_RESULT
    } t_state;

    t_state r_state;
    logic   r_m_tvalid;
    logic   w_accept;
    logic   w_load;

    assign s_tready = (r_state == ST_IDLE);
    assign w_accept = s_tvalid && s_tready;
    // Load once the output register is free or being drained this cycle.
    assign w_load   = (r_state == ST_RESULT) && (!r_m_tvalid || m_tready);

    assign o_cmd.exec     = w_accept;
    assign o_cmd.load_out = w_load;
    assign m_tvalid       = r_m_tvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_m_tvalid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_RESULT;
                    end
                end
                ST_RESULT: begin
                    if (w_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (w_load) begin
                r_m_tvalid <= 1'b1;
            end else if (m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

endmodule

FILE: sv/spq_dp.sv
`timescale 1ns / 1ps
// Datapath for the sorted priority queue: sorted slot chain and result register.
// Depends on spq_pkg.
module spq_dp
    import spq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    input  logic                 i_func,
    input  logic [VALUE_W-1:0]   i_value,
    input  logic [PRIO_W-1:0]    i_prio,
    output logic [M_TDATA_W-1:0] o_result
);

    logic [VALUE_W-1:0] r_val [QUEUE_DEPTH];
    logic [PRIO_W-1:0]  r_pri [QUEUE_DEPTH];
    logic [VALUE_W-1:0] n_val [QUEUE_DEPTH];
    logic [PRIO_W-1:0]  n_pri [QUEUE_DEPTH];
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [VALUE_W-1:0] r_popped;
    logic               r_err;
    logic [M_TDATA_W-1:0] r_result;

    logic [QUEUE_DEPTH-1:0] w_keep;
    logic w_full;
    logic w_empty;
    logic w_push_ok;
    logic w_pop_ok;
    logic [VALUE_W-1:0] w_head_val;
    logic [PRIO_W-1:0]  w_head_pri;

    assign w_full    = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_empty   = (r_count == '0);
    assign w_push_ok = (i_func == FUNC_PUSH) && !w_full;
    assign w_pop_ok  = (i_func == FUNC_POP) && !w_empty;

    // Held entries that rank ahead of the new one; a prefix of the chain.
    always_comb begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            w_keep[k] = (CNT_W'(k) < r_count) && (r_pri[k] >= i_prio);
        end
    end

    always_comb begin
        n_count = r_count;
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            n_val[k] = r_val[k];
            n_pri[k] = r_pri[k];
        end
        if (w_push_ok) begin
            n_count = r_count + 1'b1;
            if (!w_keep[0]) begin
                n_val[0] = i_value;
                n_pri[0] = i_prio;
            end
            for (int k = 1; k < QUEUE_DEPTH; k++) begin
                if (!w_keep[k]) begin
                    if (w_keep[k-1]) begin
                        n_val[k] = i_value;
                        n_pri[k] = i_prio;
                    end else begin
                        n_val[k] = r_val[k-1];
                        n_pri[k] = r_pri[k-1];
                    end
                end
            end
        end else if (w_pop_ok) begin
            n_count = r_count - 1'b1;
            for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
                n_val[k] = r_val[k+1];
                n_pri[k] = r_pri[k+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            for (int k = 0; k < QUEUE_DEPTH; k++) begin
                r_val[k] <= n_val[k];
                r_pri[k] <= n_pri[k];
            end
            r_popped <= w_pop_ok ? r_val[0] : '0;
            r_err    <= !(w_push_ok || w_pop_ok);
        end
    end

    assign w_head_val = w_empty ? '0 : r_val[0];
    assign w_head_pri = w_empty ? '0 : r_pri[0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_result <= {1'b0, r_err, w_empty, ENTRY_W'(r_count),
                         w_head_pri, w_head_val, r_popped};
        end
    end

    assign o_result = r_result;

endmodule

FILE: sv/sorted_priority_queue_core.sv
`timescale 1ns / 1ps
// Sorted priority queue, top level: controller plus sorted-chain datapath.
// Sequencing: an accepted input updates the slot chain in ST_IDLE; in ST_RESULT the
// result register is loaded and m_tvalid raised once the output is free or draining.
// No new input is accepted until the previous result has been loaded into the
// output register.
// Reset: synchronous active-low i_rst_n empties the queue and drops any result.
module sorted_priority_queue_core
    import spq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // tdata: item_value[31:0], item_priority[47:32]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // tuser: func[0] (0 push, 1 pop)
    input  logic                 s_tuser,
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // tdata: popped_value[31:0], head_value[63:32], head_priority[79:64],
    //        entry_count[84:80], is_empty[85], op_error[86], zero pad[87]
    output logic [M_TDATA_W-1:0] m_tdata
);

    t_dp_cmd w_cmd;

    // Handshakes and sequencing: accept, execute, hand the result over.
    spq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .o_cmd    (w_cmd)
    );

    // Slot chain kept in descending priority; new entries go behind equals.
    spq_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_func   (s_tuser),
        .i_value  (s_tdata[VALUE_W-1:0]),
        .i_prio   (s_tdata[VALUE_W+PRIO_W-1:VALUE_W]),
        .o_result (m_tdata)
    );

endmodule

FILE: sv/spq_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the sorted priority queue, bound to the top level.
// Depends on spq_pkg.
module spq_checker
    import spq_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // One item in flight: no new input right after an accepted one.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while previous item still executing");

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // Empty flag agrees with the count, and empty means a zero head.
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[85] == (m_tdata[84:80] == '0)) &&
                     (!m_tdata[85] || (m_tdata[79:32] == '0)))
        else $error("empty flag disagrees with count or head");

    // A dropped operation pops nothing.
    a_error_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tdata[86]) |-> (m_tdata[31:0] == '0))
        else $error("dropped operation returned a popped value");

    // Count never exceeds the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[84:80] <= ENTRY_W'(QUEUE_DEPTH)))
        else $error("entry count above queue depth");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (.*);
